// ----- hw/rtl/kzt_pkg.sv -----
`default_nettype none

package kzt_pkg;

   localparam int TABLE_SLOTS = 512;
   localparam int PROBE_LIMIT = 8;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
   localparam int HOME_SHIFT  = 4;

   localparam int KEY_W       = 64;
   localparam int POS_W       = 26;
   localparam int REG_W       = 24;
   localparam int DIFF_W      = POS_W + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int SLOT_OUT_W  = 9;

   localparam logic [POS_W-2:0] POS_MAX       = 25'd10240000;
   localparam logic [REG_W-1:0] TOL_RESET     = 24'd1024;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_X  = 2'd0,
      REG_TARGET_Y  = 2'd1,
      REG_TOLERANCE = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } back_state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             ignored;
      logic             hit;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             zone_flag;
   } slot_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

   function automatic logic axis_hit(input logic [POS_W-1:0] pos,
                                     input logic [REG_W-1:0] target,
                                     input logic [REG_W-1:0] tol);
      logic [DIFF_W-1:0] d;
      logic [DIFF_W-1:0] mag;
      d   = {pos[POS_W-1], pos} - {{(DIFF_W-REG_W){1'b0}}, target};
      mag = d[DIFF_W-1] ? (~d + 1'b1) : d;
      return mag <= {{(DIFF_W-REG_W){1'b0}}, tol};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kzt_front.sv -----
`default_nettype none

module kzt_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [kzt_pkg::KEY_W-1:0]        req_object_key,
   input  wire  signed [kzt_pkg::POS_W-1:0] req_pos_x,
   input  wire  signed [kzt_pkg::POS_W-1:0] req_pos_y,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [kzt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [kzt_pkg::REG_W-1:0]        csr_data,
   output logic                             push,
   output kzt_pkg::item_type                push_item,
   input  wire                              full,
   input  kzt_pkg::back_stat_type           back_stat
);
   import kzt_pkg::*;

   logic [REG_W-1:0] target_x_ff, target_x_in;
   logic [REG_W-1:0] target_y_ff, target_y_in;
   logic [REG_W-1:0] tolerance_ff, tolerance_in;
   logic             range_x;
   logic             range_y;

   assign csr_ready = 1'b1;
   assign busy      = full || back_stat.clearing;
   assign push      = start && !busy;

   always_comb begin
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      tolerance_in = tolerance_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TARGET_X:  target_x_in  = csr_data;
            REG_TARGET_Y:  target_y_in  = csr_data;
            REG_TOLERANCE: tolerance_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff  <= '0;
         target_y_ff  <= '0;
         tolerance_ff <= TOL_RESET;
      end else begin
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         tolerance_ff <= tolerance_in;
      end
   end

   assign range_x = !req_pos_x[POS_W-1] && (req_pos_x[POS_W-2:0] <= POS_MAX);
   assign range_y = !req_pos_y[POS_W-1] && (req_pos_y[POS_W-2:0] <= POS_MAX);

   always_comb begin
      push_item.key     = req_object_key;
      push_item.ignored = (req_object_key == '0) || !range_x || !range_y;
      push_item.hit     = axis_hit(req_pos_x, target_x_ff, tolerance_ff)
                          && axis_hit(req_pos_y, target_y_ff, tolerance_ff);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/kzt_queue.sv -----
`default_nettype none

module kzt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  kzt_pkg::item_type push_item,
   input  wire               pop,
   output kzt_pkg::item_type head,
   output logic              full,
   output logic              empty
);
   import kzt_pkg::*;

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/kzt_back.sv -----
`default_nettype none

module kzt_back (
   input  wire                            clock,
   input  wire                            reset,
   input  kzt_pkg::item_type              head,
   input  wire                            empty,
   output logic                           pop,
   output kzt_pkg::back_stat_type         back_stat,
   output logic                           rsp_valid,
   output logic                           rsp_ignored,
   output logic                           rsp_in_zone,
   output logic                           rsp_enter_event,
   output logic                           rsp_exit_event,
   output logic [kzt_pkg::SLOT_OUT_W-1:0] rsp_slot_used,
   output logic                           rsp_recycled
);
   import kzt_pkg::*;

   slot_type            slot_mem [TABLE_SLOTS];
   slot_type            rd_data_ff;
   logic [SLOT_W-1:0]   rd_addr;
   logic                we;
   logic [SLOT_W-1:0]   wr_addr;
   slot_type            wr_data;

   back_state_type      state_ff, state_in;
   item_type            cur_ff, cur_in;
   logic [PROBE_W-1:0]  probe_ff, probe_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ignored_ff, rsp_ignored_in;
   logic                rsp_in_zone_ff, rsp_in_zone_in;
   logic                rsp_enter_ff, rsp_enter_in;
   logic                rsp_exit_ff, rsp_exit_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_recycled_ff, rsp_recycled_in;

   logic [SLOT_W-1:0]   home_cur;
   logic [SLOT_W-1:0]   probe_addr;
   logic                match;
   logic                vacant;
   logic                last;
   logic                old_inside;

   assign home_cur   = cur_ff.key[HOME_SHIFT +: SLOT_W];
   assign probe_addr = home_cur + SLOT_W'(probe_ff);
   assign match      = rd_data_ff.key == cur_ff.key;
   assign vacant     = rd_data_ff.key == '0;
   assign last       = probe_ff == PROBE_W'(PROBE_LIMIT - 1);
   assign old_inside = match && rd_data_ff.zone_flag;

   assign back_stat.clearing = state_ff == ST_CLEAR;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      probe_in        = probe_ff;
      clr_in          = clr_ff;
      pop             = 1'b0;
      rd_addr         = probe_addr + 1'b1;
      we              = 1'b0;
      wr_addr         = probe_addr;
      wr_data         = '0;
      rsp_valid_in    = 1'b0;
      rsp_ignored_in  = rsp_ignored_ff;
      rsp_in_zone_in  = rsp_in_zone_ff;
      rsp_enter_in    = rsp_enter_ff;
      rsp_exit_in     = rsp_exit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_recycled_in = rsp_recycled_ff;
      case (state_ff)
         ST_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = head.key[HOME_SHIFT +: SLOT_W];
            if (!empty) begin
               pop      = 1'b1;
               cur_in   = head;
               probe_in = '0;
               if (head.ignored) begin
                  rsp_valid_in    = 1'b1;
                  rsp_ignored_in  = 1'b1;
                  rsp_in_zone_in  = 1'b0;
                  rsp_enter_in    = 1'b0;
                  rsp_exit_in     = 1'b0;
                  rsp_slot_in     = '0;
                  rsp_recycled_in = 1'b0;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (match || vacant || last) begin
               we                = 1'b1;
               wr_addr           = (match || vacant) ? probe_addr : home_cur;
               wr_data.key       = cur_ff.key;
               wr_data.zone_flag = cur_ff.hit;
               rsp_valid_in      = 1'b1;
               rsp_ignored_in    = 1'b0;
               rsp_in_zone_in    = cur_ff.hit;
               rsp_enter_in      = cur_ff.hit && !old_inside;
               rsp_exit_in       = !cur_ff.hit && old_inside;
               rsp_slot_in       = wr_addr;
               rsp_recycled_in   = !match && !vacant;
               state_in          = ST_IDLE;
            end else begin
               probe_in = probe_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      probe_ff        <= probe_in;
      rsp_ignored_ff  <= rsp_ignored_in;
      rsp_in_zone_ff  <= rsp_in_zone_in;
      rsp_enter_ff    <= rsp_enter_in;
      rsp_exit_ff     <= rsp_exit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_recycled_ff <= rsp_recycled_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ignored     = rsp_ignored_ff;
   assign rsp_in_zone     = rsp_in_zone_ff;
   assign rsp_enter_event = rsp_enter_ff;
   assign rsp_exit_event  = rsp_exit_ff;
   assign rsp_slot_used   = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_recycled    = rsp_recycled_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_zone_enter_exit_tracker.sv -----
// Zone enter/exit tracker. After reset the slot table is cleared with busy
// high. An item transfers when start is high and busy low; it is
// range-checked and compared to the target on entry, then queued (two
// entries) for the table unit. The table unit dequeues one item at a time
// and probes its single-read-port slot memory: an ignored item is answered
// without probing, a tracked one after up to eight probes. Each result shows
// for one cycle with rsp_valid high, in input order; the receiver cannot
// stall it.
`default_nettype none

module keyed_zone_enter_exit_tracker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [kzt_pkg::KEY_W-1:0]        req_object_key,
   input  wire  signed [kzt_pkg::POS_W-1:0] req_pos_x,
   input  wire  signed [kzt_pkg::POS_W-1:0] req_pos_y,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [kzt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [kzt_pkg::REG_W-1:0]        csr_data,
   output logic                             rsp_valid,
   output logic                             rsp_ignored,
   output logic                             rsp_in_zone,
   output logic                             rsp_enter_event,
   output logic                             rsp_exit_event,
   output logic [kzt_pkg::SLOT_OUT_W-1:0]   rsp_slot_used,
   output logic                             rsp_recycled
);
   import kzt_pkg::*;

   logic          push;
   item_type      push_item;
   logic          pop;
   item_type      head;
   logic          full;
   logic          empty;
   back_stat_type back_stat;

   kzt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_object_key (req_object_key),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (push),
      .push_item      (push_item),
      .full           (full),
      .back_stat      (back_stat)
   );

   kzt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   kzt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .back_stat       (back_stat),
      .rsp_valid       (rsp_valid),
      .rsp_ignored     (rsp_ignored),
      .rsp_in_zone     (rsp_in_zone),
      .rsp_enter_event (rsp_enter_event),
      .rsp_exit_event  (rsp_exit_event),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_recycled    (rsp_recycled)
   );

endmodule

`default_nettype wire

// ----- sim/keyed_zone_enter_exit_tracker_test.sv -----
`timescale 1ns / 1ps

module keyed_zone_enter_exit_tracker_test;
   import kzt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 138;
   localparam int CLUSTERS       = 4;
   localparam int CLUSTER_KEYS   = 10;
   localparam int POOL_SIZE      = CLUSTERS * CLUSTER_KEYS;
   localparam int PRINT_LIMIT    = 100;
   localparam longint RANGE_TOP  = 10240000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic                  ignored;
      logic                  in_zone;
      logic                  enter_event;
      logic                  exit_event;
      logic [SLOT_OUT_W-1:0] slot_used;
      logic                  recycled;
   } zone_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [KEY_W-1:0]      req_object_key;
   logic signed [POS_W-1:0] req_pos_x;
   logic signed [POS_W-1:0] req_pos_y;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_data;
   logic                  rsp_valid;
   logic                  rsp_ignored;
   logic                  rsp_in_zone;
   logic                  rsp_enter_event;
   logic                  rsp_exit_event;
   logic [SLOT_OUT_W-1:0] rsp_slot_used;
   logic                  rsp_recycled;

   logic [KEY_W-1:0] table_key [TABLE_SLOTS];
   bit               table_inside [TABLE_SLOTS];
   logic [REG_W-1:0] zone_x;
   logic [REG_W-1:0] zone_y;
   logic [REG_W-1:0] zone_tol;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   zone_report_type  expected_reports [$];
   bit               burst;
   int               errors;
   int               idle_cycles;
   int               n_reports;
   int               n_ignored;
   int               n_enter;
   int               n_exit;
   int               n_recycled;

   keyed_zone_enter_exit_tracker uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_object_key  (req_object_key),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ignored     (rsp_ignored),
      .rsp_in_zone     (rsp_in_zone),
      .rsp_enter_event (rsp_enter_event),
      .rsp_exit_event  (rsp_exit_event),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_recycled    (rsp_recycled)
   );

   always #4 clock = ~clock;

   function automatic longint axis_distance(longint pos, logic [REG_W-1:0] aim);
      longint d;
      d = pos - longint'(aim);
      return (d < 0) ? -d : d;
   endfunction

   function automatic zone_report_type predict_zone_report(input logic [KEY_W-1:0] key,
                                                           input logic signed [POS_W-1:0] px,
                                                           input logic signed [POS_W-1:0] py);
      zone_report_type r;
      longint          x;
      longint          y;
      int              home;
      int              s;
      int              i;
      bit              found;
      r = '0;
      x = longint'(px);
      y = longint'(py);
      if (key == '0 || x < 0 || x > RANGE_TOP || y < 0 || y > RANGE_TOP) begin
         r.ignored = 1'b1;
         return r;
      end
      r.in_zone = axis_distance(x, zone_x) <= longint'(zone_tol) &&
                  axis_distance(y, zone_y) <= longint'(zone_tol);
      home = int'(key[HOME_SHIFT +: SLOT_W]);
      s = home;
      found = 1'b0;
      for (i = 0; i < PROBE_LIMIT && !found; i++) begin
         s = (home + i) % TABLE_SLOTS;
         if (table_key[s] == key) begin
            found = 1'b1;
         end else if (table_key[s] == '0) begin
            table_key[s] = key;
            table_inside[s] = 1'b0;
            found = 1'b1;
         end
      end
      if (!found) begin
         s = home;
         table_key[s] = key;
         table_inside[s] = 1'b0;
         r.recycled = 1'b1;
      end
      if (r.in_zone && !table_inside[s]) begin
         table_inside[s] = 1'b1;
         r.enter_event = 1'b1;
      end else if (!r.in_zone && table_inside[s]) begin
         table_inside[s] = 1'b0;
         r.exit_event = 1'b1;
      end
      r.slot_used = s[SLOT_OUT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      zone_report_type want;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= PRINT_LIMIT)
               $display("%0t: report with none expected, expected nothing got slot %0d",
                        $time, rsp_slot_used);
         end else begin
            want = expected_reports.pop_front();
            check_field("ignored", want.ignored, rsp_ignored);
            check_field("in_zone", want.in_zone, rsp_in_zone);
            check_field("enter_event", want.enter_event, rsp_enter_event);
            check_field("exit_event", want.exit_event, rsp_exit_event);
            check_field("slot_used", want.slot_used, rsp_slot_used);
            check_field("recycled", want.recycled, rsp_recycled);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("keyed_zone_enter_exit_tracker_test: FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic [KEY_W-1:0] key,
                            input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py);
      int              gap;
      zone_report_type r;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_object_key <= key;
      req_pos_x      <= px;
      req_pos_y      <= py;
      do @(posedge clock); while (busy);
      r = predict_zone_report(key, px, py);
      expected_reports.push_back(r);
      n_reports++;
      n_ignored  += r.ignored;
      n_enter    += r.enter_event;
      n_exit     += r.exit_event;
      n_recycled += r.recycled;
   endtask

   task automatic drain_reports();
      start <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TARGET_X:  zone_x   = data;
         REG_TARGET_Y:  zone_y   = data;
         REG_TOLERANCE: zone_tol = data;
         default: ;
      endcase
   endtask

   task automatic configure_zone(input logic [REG_W-1:0] tx, input logic [REG_W-1:0] ty,
                                 input logic [REG_W-1:0] tol, input bit spare);
      drain_reports();
      write_reg(REG_TARGET_X, tx);
      write_reg(REG_TARGET_Y, ty);
      write_reg(REG_TOLERANCE, tol);
      if (spare)
         write_reg(REG_SPARE, REG_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [POS_W-1:0] near_target(input logic [REG_W-1:0] aim);
      longint d;
      longint p;
      case ($urandom_range(0, 3))
         0:       d = longint'(zone_tol);
         1:       d = longint'(zone_tol) + 1;
         default: d = $urandom_range(0, zone_tol + 2);
      endcase
      if ($urandom_range(0, 1))
         d = -d;
      p = longint'(aim) + d;
      if (p < 0)
         p = 0;
      if (p > RANGE_TOP)
         p = RANGE_TOP;
      return p[POS_W-1:0];
   endfunction

   task automatic build_key_pool();
      int               c;
      int               j;
      int               home;
      logic [KEY_W-1:0] key;
      for (c = 0; c < CLUSTERS; c++) begin
         home = (c == CLUSTERS - 1) ? TABLE_SLOTS - 4 : $urandom_range(0, TABLE_SLOTS - 1);
         for (j = 0; j < CLUSTER_KEYS; j++) begin
            key = {$urandom, $urandom};
            key[HOME_SHIFT +: SLOT_W] = SLOT_W'(home);
            if (key == '0)
               key[KEY_W-1] = 1'b1;
            key_pool[c * CLUSTER_KEYS + j] = key;
         end
      end
   endtask

   task automatic test_default_zone();
      send_item(64'h640, 0, 0);
      send_item(64'h640, 1024, 1024);
      send_item(64'h640, 1025, 0);
      send_item(64'h640, 26'(RANGE_TOP), 26'(RANGE_TOP));
   endtask

   task automatic test_ignored_inputs();
      send_item(64'h0, 5, 5);
      send_item(64'h640, -1, 0);
      send_item(64'h640, 26'(RANGE_TOP + 1), 0);
      send_item(64'h640, 0, -26'sd33554432);
      send_item(64'h640, 0, 26'sd33554431);
      send_item(64'h640, 26'sd33554431, -1);
   endtask

   task automatic test_probe_chain();
      int i;
      for (i = 1; i <= PROBE_LIMIT + 1; i++)
         send_item((64'(i) << 13) | (64'd37 << HOME_SHIFT) | 64'(i),
                   (i % 2) ? 26'sd0 : 26'sd5000, 0);
      send_item((64'd1 << 13) | (64'd37 << HOME_SHIFT) | 64'd1, 0, 0);
   endtask

   task automatic test_slot_wrap();
      send_item({KEY_W{1'b1}}, 0, 0);
      send_item((64'd5 << 13) | (64'(TABLE_SLOTS - 1) << HOME_SHIFT), 2048, 0);
   endtask

   task automatic test_random_phase(input logic [REG_W-1:0] tx, input logic [REG_W-1:0] ty,
                                    input logic [REG_W-1:0] tol, input bit spare);
      int                      n;
      int                      kind;
      logic [KEY_W-1:0]        key;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      configure_zone(tx, ty, tol, spare);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 32 == 0)
            burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 59) == 0)
            drain_reports();
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 1)) begin
               px = near_target(zone_x);
               py = near_target(zone_y);
            end else begin
               px = POS_W'($urandom_range(0, RANGE_TOP));
               py = POS_W'($urandom_range(0, RANGE_TOP));
            end
         end else if (kind < 85) begin
            key = {$urandom, $urandom};
            px  = POS_W'($urandom_range(0, RANGE_TOP));
            py  = POS_W'($urandom_range(0, RANGE_TOP));
         end else begin
            key = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
            px  = POS_W'($urandom);
            py  = POS_W'($urandom);
         end
         send_item(key, px, py);
      end
      burst = 1'b0;
   endtask

   initial begin
      int s;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_object_key <= '0;
      req_pos_x      <= '0;
      req_pos_y      <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= REG_TARGET_X;
      csr_data       <= '0;
      for (s = 0; s < TABLE_SLOTS; s++) begin
         table_key[s]    = '0;
         table_inside[s] = 1'b0;
      end
      zone_x   = '0;
      zone_y   = '0;
      zone_tol = TOL_RESET;
      burst    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      build_key_pool();
      test_default_zone();
      test_ignored_inputs();
      test_probe_chain();
      test_slot_wrap();
      test_random_phase(24'd5120000, 24'd5120000, 24'd1024, 1'b1);
      test_random_phase(24'd0, 24'd0, 24'd0, 1'b0);
      test_random_phase(24'd10240000, 24'd10240000, 24'd10240000, 1'b0);
      test_random_phase(24'd3000000, 24'd7000000, 24'd50000, 1'b1);
      test_random_phase(24'hFFFFFF, 24'd0, 24'hFFFFFF, 1'b0);
      test_random_phase(REG_W'($urandom_range(0, RANGE_TOP)), REG_W'($urandom_range(0, RANGE_TOP)),
                        REG_W'($urandom_range(0, 200000)), 1'b1);

      drain_reports();
      repeat (16) @(posedge clock);

      $display("covered %0d position updates over six zone settings and directed edge cases",
               n_reports);
      $display("  %0d ignored, %0d enters, %0d exits, %0d home slot recycles",
               n_ignored, n_enter, n_exit, n_recycled);
      if (errors == 0)
         $display("keyed_zone_enter_exit_tracker_test: PASS");
      else
         $display("keyed_zone_enter_exit_tracker_test: FAIL");
      $finish;
   end

endmodule
